/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when synthesizing
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

/* design/ampwm_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ampwm_pkg
// shared types, codes and constants of the addressed multichannel pwm core
// ---------------------------------------------------------------------------
package ampwm_pkg;

   localparam int CHANNELS_DEFAULT = 32;
   localparam int OUT_W            = 32;   // width of the channel output word
   localparam int LEVEL_W          = 8;
   localparam int BYTE_W           = 8;
   localparam int FRAME_LEN        = 32;   // longest frame payload (level load)
   localparam int FRAME_IDX_W      = $clog2(FRAME_LEN);
   localparam int COUNT_W          = $clog2(FRAME_LEN + 1);
   localparam logic [LEVEL_W-1:0] LEVEL_RESET = 8'd129;

   // item opcodes
   localparam logic OP_SERIAL = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   typedef enum logic [1:0] {
      LINK_WAIT,
      LINK_CMD,
      LINK_DATA,
      LINK_DROP
   } link_state_type;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_SET,
      CMD_STEP
   } cmd_type;

   typedef logic [FRAME_LEN-1:0][BYTE_W-1:0] frame_type;

   // command decoded by the link, applied by the pwm engine
   typedef struct packed {
      logic               load_all;
      logic               set_one;
      logic               set_step;
      logic [BYTE_W-1:0]  chan;
      logic [LEVEL_W-1:0] level;
      logic [BYTE_W-1:0]  step_exp;
   } update_type;

   function automatic logic [COUNT_W-1:0] frame_len(cmd_type cmd);
      logic [COUNT_W-1:0] len;
      case (cmd)
         CMD_LOAD: len = COUNT_W'(FRAME_LEN);
         CMD_SET:  len = COUNT_W'(2);
         CMD_STEP: len = COUNT_W'(1);
         default:  len = '0;
      endcase
      return len;
   endfunction

endpackage

/* design/ampwm_link.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ampwm_link
// multidrop frame parser: address match, command decode and frame buffer
// ---------------------------------------------------------------------------
module ampwm_link (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              serial_fire,
   input  logic [ampwm_pkg::BYTE_W-1:0]      serial_byte,
   input  logic                              ninth_bit,
   input  logic [ampwm_pkg::BYTE_W-1:0]      node_address,
   output ampwm_pkg::update_type             upd,
   output ampwm_pkg::frame_type              frame_view
);

   ampwm_pkg::link_state_type             state_ff, state_in;
   ampwm_pkg::cmd_type                    pending_ff, pending_in;
   logic [ampwm_pkg::COUNT_W-1:0]         taken_ff, taken_in;
   logic [ampwm_pkg::COUNT_W-1:0]         count_next;
   logic                                  frame_we;
   logic [ampwm_pkg::BYTE_W-1:0]          frame_ff [ampwm_pkg::FRAME_LEN];

   // frame bytes with the byte arriving now bypassed into its slot
   always_comb begin
      for (int j = 0; j < ampwm_pkg::FRAME_LEN; j++) begin
         if (taken_ff[ampwm_pkg::FRAME_IDX_W-1:0] == ampwm_pkg::FRAME_IDX_W'(j)) begin
            frame_view[j] = serial_byte;
         end else begin
            frame_view[j] = frame_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ampwm_pkg::LINK_WAIT;
         pending_ff <= ampwm_pkg::CMD_NONE;
         taken_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
         taken_ff   <= taken_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_we) begin
         frame_ff[taken_ff[ampwm_pkg::FRAME_IDX_W-1:0]] <= serial_byte;
      end
   end

   always_comb begin
      state_in     = state_ff;
      pending_in   = pending_ff;
      taken_in     = taken_ff;
      frame_we     = 1'b0;
      count_next   = taken_ff + ampwm_pkg::COUNT_W'(1);
      upd          = '0;
      upd.chan     = frame_view[0];
      upd.level    = frame_view[1];
      upd.step_exp = frame_view[0];
      if (serial_fire) begin
         case (state_ff)
            ampwm_pkg::LINK_WAIT: begin
               if (ninth_bit && serial_byte == node_address) begin
                  state_in = ampwm_pkg::LINK_CMD;
               end
            end
            ampwm_pkg::LINK_CMD: begin
               if (ninth_bit) begin
                  state_in = ampwm_pkg::LINK_WAIT;
               end else if (serial_byte[ampwm_pkg::BYTE_W-1:2] == '0 &&
                            serial_byte[1:0] != ampwm_pkg::CMD_NONE) begin
                  pending_in = ampwm_pkg::cmd_type'(serial_byte[1:0]);
                  taken_in   = '0;
                  state_in   = ampwm_pkg::LINK_DATA;
               end else begin
                  pending_in = ampwm_pkg::CMD_NONE;
                  taken_in   = '0;
                  state_in   = ampwm_pkg::LINK_DROP;
               end
            end
            ampwm_pkg::LINK_DATA: begin
               if (ninth_bit) begin
                  // address mid-frame aborts it
                  state_in   = ampwm_pkg::LINK_WAIT;
                  pending_in = ampwm_pkg::CMD_NONE;
                  taken_in   = '0;
               end else begin
                  frame_we = 1'b1;
                  taken_in = count_next;
                  if (count_next >= ampwm_pkg::frame_len(pending_ff)) begin
                     upd.load_all = (pending_ff == ampwm_pkg::CMD_LOAD);
                     upd.set_one  = (pending_ff == ampwm_pkg::CMD_SET);
                     upd.set_step = (pending_ff == ampwm_pkg::CMD_STEP);
                     pending_in   = ampwm_pkg::CMD_NONE;
                     taken_in     = '0;
                     state_in     = ampwm_pkg::LINK_WAIT;
                  end
               end
            end
            ampwm_pkg::LINK_DROP: begin
               if (ninth_bit) begin
                  state_in   = ampwm_pkg::LINK_WAIT;
                  pending_in = ampwm_pkg::CMD_NONE;
                  taken_in   = '0;
               end
            end
            default: begin
               state_in = ampwm_pkg::LINK_WAIT;
            end
         endcase
      end
   end

endmodule

/* design/ampwm_engine.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ampwm_engine
// level table, phase step, phase counter and per-channel compare
// ---------------------------------------------------------------------------
module ampwm_engine #(
   parameter int CHANNELS = ampwm_pkg::CHANNELS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ampwm_pkg::update_type              upd,
   input  ampwm_pkg::frame_type               frame_view,
   input  logic                               tick_fire,
   output logic [ampwm_pkg::OUT_W-1:0]        drive,
   output logic [ampwm_pkg::LEVEL_W-1:0]      phase
);

   localparam int LIVE  = (CHANNELS < ampwm_pkg::OUT_W) ? CHANNELS : ampwm_pkg::OUT_W;
   localparam int IDX_W = $clog2(LIVE);
   localparam logic [ampwm_pkg::OUT_W-1:0] LIVE_MASK =
      ampwm_pkg::OUT_W'((64'd1 << LIVE) - 64'd1);

   logic [ampwm_pkg::LEVEL_W-1:0] levels_ff [LIVE];
   logic [ampwm_pkg::LEVEL_W-1:0] levels_in [LIVE];
   logic [ampwm_pkg::LEVEL_W-1:0] step_ff, step_in;
   logic [ampwm_pkg::LEVEL_W-1:0] phase_ff, phase_in, phase_sum;
   logic [ampwm_pkg::OUT_W-1:0]   drive_ff, drive_in, drive_calc;
   logic [ampwm_pkg::BYTE_W-1:0]  chan_map;

   // low four slots of every group of eight come reversed
   assign chan_map = {upd.chan[ampwm_pkg::BYTE_W-1:2],
                      upd.chan[2] ? upd.chan[1:0] : ~upd.chan[1:0]};

   always_comb begin
      logic [ampwm_pkg::FRAME_IDX_W-1:0] src;
      src = '0;
      for (int i = 0; i < LIVE; i++) begin
         levels_in[i] = levels_ff[i];
      end
      if (upd.load_all) begin
         for (int i = 0; i < LIVE; i++) begin
            src = ampwm_pkg::FRAME_IDX_W'(i);
            if (!src[2]) begin
               src[1:0] = ~src[1:0];
            end
            levels_in[i] = frame_view[src];
         end
      end
      if (upd.set_one && chan_map < ampwm_pkg::BYTE_W'(LIVE)) begin
         levels_in[chan_map[IDX_W-1:0]] = upd.level;
      end
   end

   always_comb begin
      step_in = step_ff;
      if (upd.set_step) begin
         if (upd.step_exp[ampwm_pkg::BYTE_W-1:3] == '0) begin
            step_in = ampwm_pkg::LEVEL_W'(1) << upd.step_exp[2:0];
         end else begin
            step_in = ampwm_pkg::LEVEL_W'(1);
         end
      end
   end

   assign phase_sum = phase_ff + step_ff;

   always_comb begin
      drive_calc = (phase_sum == '0) ? LIVE_MASK : drive_ff;
      for (int i = 0; i < LIVE; i++) begin
         if (phase_sum >= levels_ff[i]) begin
            drive_calc[i] = 1'b0;
         end
      end
   end

   assign phase_in = tick_fire ? phase_sum : phase_ff;
   assign drive_in = tick_fire ? drive_calc : drive_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LIVE; i++) begin
            levels_ff[i] <= ampwm_pkg::LEVEL_RESET;
         end
         step_ff  <= ampwm_pkg::LEVEL_W'(1);
         phase_ff <= '0;
         drive_ff <= '0;
      end else begin
         for (int i = 0; i < LIVE; i++) begin
            levels_ff[i] <= levels_in[i];
         end
         step_ff  <= step_in;
         phase_ff <= phase_in;
         drive_ff <= drive_in;
      end
   end

   assign drive = drive_ff;
   assign phase = phase_ff;

endmodule

/* design/addressed_multichannel_pwm_core.sv */
`timescale 1ns / 1ps
// result path: a tick goes from the input register into the phase, drive and rsp_valid registers
// throughput: one transaction per cycle, serial bytes and ticks alike, unless a result waits;
// set by the input register and the single pass through link decode and per-channel level compare
// reset: synchronous active high; link waits for address, levels 129, step 1, phase 0, outputs 0
// ---------------------------------------------------------------------------
// addressed_multichannel_pwm_core
// pwm controller for up to 32 channels commanded over a 9-bit multidrop link
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module addressed_multichannel_pwm_core #(
   parameter int CHANNELS = ampwm_pkg::CHANNELS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // input transactions: serial characters and ticks
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_opcode,
   input  logic [ampwm_pkg::BYTE_W-1:0]       req_serial_byte,
   input  logic                               req_ninth_bit,
   // result transactions, one per tick
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ampwm_pkg::OUT_W-1:0]        rsp_channel_outputs,
   output logic [ampwm_pkg::LEVEL_W-1:0]      rsp_phase,
   // node address register
   input  logic                               csr_wr_en,
   input  logic [ampwm_pkg::BYTE_W-1:0]       csr_wr_data
);

   logic [ampwm_pkg::BYTE_W-1:0] node_address_ff;

   // input register
   logic                         stage_valid_ff, stage_valid_in;
   logic                         stage_op_ff;
   logic [ampwm_pkg::BYTE_W-1:0] stage_byte_ff;
   logic                         stage_ninth_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         out_free;
   logic                         stage_fire;
   logic                         serial_fire;
   logic                         tick_fire;
   logic                         req_fire;

   ampwm_pkg::update_type        upd;
   ampwm_pkg::frame_type         frame_view;

   // a tick may leave the input register only when the result slot frees up;
   // serial characters never wait on the result side
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign stage_fire  = stage_valid_ff && (stage_op_ff == ampwm_pkg::OP_SERIAL || out_free);
   assign serial_fire = stage_fire && stage_op_ff == ampwm_pkg::OP_SERIAL;
   assign tick_fire   = stage_fire && stage_op_ff == ampwm_pkg::OP_TICK;
   assign req_ready   = !stage_valid_ff || stage_fire;
   assign req_fire    = req_valid && req_ready;

   assign stage_valid_in = req_fire || (stage_valid_ff && !stage_fire);
   assign rsp_valid_in   = tick_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         node_address_ff <= '0;
         stage_valid_ff  <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            node_address_ff <= csr_wr_data;
         end
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload of the input register, loaded on every accepted transaction
   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_op_ff    <= req_opcode;
         stage_byte_ff  <= req_serial_byte;
         stage_ninth_ff <= req_ninth_bit;
      end
   end

   ampwm_link u_link (
      .clock        (clock),
      .reset        (reset),
      .serial_fire  (serial_fire),
      .serial_byte  (stage_byte_ff),
      .ninth_bit    (stage_ninth_ff),
      .node_address (node_address_ff),
      .upd          (upd),
      .frame_view   (frame_view)
   );

   // phase and drive registers only move on a tick, so they double as the
   // result payload while rsp_valid waits for rsp_ready
   ampwm_engine #(
      .CHANNELS (CHANNELS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .upd        (upd),
      .frame_view (frame_view),
      .tick_fire  (tick_fire),
      .drive      (rsp_channel_outputs),
      .phase      (rsp_phase)
   );

   assign rsp_valid = rsp_valid_ff;

   // a tick leaving the input register always produces a result next cycle
   `ASSERT_PROP(a_tick_gives_rsp, clock, reset, tick_fire |=> rsp_valid)
   // serial characters never disturb the pwm output state
   `ASSERT_PROP(a_serial_keeps_out, clock, reset,
      serial_fire |=> $stable(rsp_channel_outputs) && $stable(rsp_phase))
   // back-pressure on the input only comes from an occupied input register
   `ASSERT_NEVER(a_ready_low_empty, clock, reset, !req_ready && !stage_valid_ff)

endmodule
